// File: rtl/core/ipc_pkg.sv
// Shared types, codes and decode functions for the infix-to-postfix converter.
// Self-contained; used by ipc_stack_ram and infix_to_postfix_converter_top.
package ipc_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int DATA_W          = 8;
    localparam int USER_W          = 3;
    localparam int CODE_W          = 3;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [DATA_W-1:0] char_t;

    // operator codes as kept on the stack
    localparam code_t CODE_LPAREN = 3'd0;
    localparam code_t CODE_PLUS   = 3'd1;
    localparam code_t CODE_MINUS  = 3'd2;
    localparam code_t CODE_MUL    = 3'd3;
    localparam code_t CODE_DIV    = 3'd4;
    localparam code_t CODE_POW    = 3'd5;

    localparam char_t CH_NUL    = 8'h00;
    localparam char_t CH_LPAREN = 8'h28;
    localparam char_t CH_RPAREN = 8'h29;
    localparam char_t CH_MUL    = 8'h2A;
    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_DIV    = 8'h2F;
    localparam char_t CH_POW    = 8'h5E;
    localparam char_t CH_0      = 8'h30;
    localparam char_t CH_9      = 8'h39;
    localparam char_t CH_UA     = 8'h41;
    localparam char_t CH_UZ     = 8'h5A;
    localparam char_t CH_LA     = 8'h61;
    localparam char_t CH_LZ     = 8'h7A;

    // what the pop loop is working on
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CLOSE = 2'd0;
    localparam kind_t KIND_OP    = 2'd1;
    localparam kind_t KIND_FLUSH = 2'd2;

    typedef struct packed {
        char_t ch;
        logic  cvalid;
        logic  last;
        logic  done;
        logic  ovf;
    } result_t;

    function automatic logic is_alnum(input char_t c);
        is_alnum = ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
                   ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    // returns CODE_LPAREN when c is not an operator
    function automatic code_t op_code(input char_t c);
        code_t r;
        unique case (c)
            CH_PLUS:  r = CODE_PLUS;
            CH_MINUS: r = CODE_MINUS;
            CH_MUL:   r = CODE_MUL;
            CH_DIV:   r = CODE_DIV;
            CH_POW:   r = CODE_POW;
            default:  r = CODE_LPAREN;
        endcase
        op_code = r;
    endfunction

    function automatic logic [1:0] prec(input code_t code);
        logic [1:0] r;
        unique case (code)
            CODE_PLUS, CODE_MINUS: r = 2'd1;
            CODE_MUL, CODE_DIV:    r = 2'd2;
            CODE_POW:              r = 2'd3;
            default:               r = 2'd0;
        endcase
        prec = r;
    endfunction

    function automatic char_t sym(input code_t code);
        char_t r;
        unique case (code)
            CODE_LPAREN: r = CH_LPAREN;
            CODE_PLUS:   r = CH_PLUS;
            CODE_MINUS:  r = CH_MINUS;
            CODE_MUL:    r = CH_MUL;
            CODE_DIV:    r = CH_DIV;
            CODE_POW:    r = CH_POW;
            default:     r = CH_NUL;
        endcase
        sym = r;
    endfunction

endpackage

// File: rtl/core/infix_to_postfix_converter_top.sv
// Shunting-yard infix-to-postfix converter, top level. Uses ipc_pkg and ipc_stack_ram.
// Operators wait on a stack held in a single-port-read synchronous RAM.
//
// One character is taken per input transfer (s_tlast ends the expression) and
// the postfix characters leave one per output transfer; m_tlast marks the last
// result of each input character. An item passes accept, the emit, evaluate
// and push steps it needs, end check and finish. The stack RAM returns one
// entry per cycle, so each popped operator and each flushed entry takes an
// evaluate step, which waits while the hold register cannot pass its result
// on. An end item makes one more evaluate step to find the stack empty; an
// item with results waits for its last result to leave the hold register
// before the next transfer is accepted. A finished result waits in an output
// register so the next character can be accepted while the sink stalls.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = ipc_pkg::STACK_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ipc_pkg::DATA_W-1:0]   s_tdata,   // [7:0] in_char
    input  logic                         s_tlast,   // expr_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ipc_pkg::DATA_W-1:0]   m_tdata,   // [7:0] out_char
    output logic [ipc_pkg::USER_W-1:0]   m_tuser,   // [0] char_valid, [1] expr_done, [2] overflow
    output logic                         m_tlast    // run_last
);
    import ipc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EMIT   = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_PUSH   = 3'd3;
    localparam logic [2:0] ST_ENDCHK = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    kind_t         kind_reg, kind_next;
    code_t         code_reg, code_next;
    char_t         char_reg, char_next;
    logic          end_reg, end_next;
    logic          hold_vld_reg, hold_vld_next;
    logic          hold_final_reg, hold_final_next;
    result_t       hold_reg, hold_next;
    logic          out_vld_reg, out_vld_next;
    result_t       out_reg, out_next;

    logic          out_free, emit_ok, move, accept, pop;
    code_t         top_code, in_code;
    logic [CW-1:0] cnt_dec;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    ipc_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (code_reg),
        .raddr (rd_addr),
        .rdata (top_code)
    );

    assign out_free = !out_vld_reg || m_tready;
    assign emit_ok  = !hold_vld_reg || out_free;
    assign s_tready = (state_reg == ST_IDLE) && !hold_vld_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_code  = op_code(s_tdata);

    // read address follows the top of stack as it will stand next cycle
    assign cnt_dec = count_next - CW'(1);
    assign rd_addr = cnt_dec[AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        kind_next       = kind_reg;
        code_next       = code_reg;
        char_next       = char_reg;
        end_next        = end_reg;
        hold_vld_next   = hold_vld_reg;
        hold_final_next = hold_final_reg;
        hold_next       = hold_reg;
        out_vld_next    = out_vld_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        pop             = 1'b0;

        // held result goes out once its successor exists or the item is done
        move = hold_vld_reg && out_free && (hold_final_reg ||
               (state_reg == ST_EMIT && emit_ok) ||
               (state_reg == ST_EVAL && count_reg != '0 && emit_ok &&
                (kind_reg == KIND_FLUSH ||
                 (top_code != CODE_LPAREN &&
                  (kind_reg == KIND_CLOSE || prec(top_code) >= prec(code_reg))))));
        if (move)
        begin
            out_next        = hold_reg;
            out_vld_next    = 1'b1;
            hold_vld_next   = 1'b0;
            hold_final_next = 1'b0;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    char_next = s_tdata;
                    end_next  = s_tlast;
                    if (is_alnum(s_tdata))
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (s_tdata == CH_LPAREN)
                    begin
                        code_next  = CODE_LPAREN;
                        state_next = ST_PUSH;
                    end
                    else if (s_tdata == CH_RPAREN)
                    begin
                        kind_next  = KIND_CLOSE;
                        state_next = ST_EVAL;
                    end
                    else if (in_code != CODE_LPAREN)
                    begin
                        kind_next  = KIND_OP;
                        code_next  = in_code;
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        state_next = ST_ENDCHK;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    hold_next     = '{ch: char_reg, cvalid: 1'b1, last: 1'b0,
                                      done: 1'b0, ovf: ovf_reg};
                    hold_vld_next = 1'b1;
                    state_next    = ST_ENDCHK;
                end
            end
            ST_EVAL:
            begin
                if (count_reg == '0)
                begin
                    if (kind_reg == KIND_OP)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (kind_reg == KIND_CLOSE)
                    begin
                        state_next = ST_ENDCHK;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (kind_reg == KIND_FLUSH)
                begin
                    pop = 1'b1;
                end
                else if (top_code == CODE_LPAREN)
                begin
                    if (kind_reg == KIND_CLOSE)
                    begin
                        // matching '(' is dropped
                        count_next = count_reg - CW'(1);
                        state_next = ST_ENDCHK;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
                else if (kind_reg == KIND_CLOSE || prec(top_code) >= prec(code_reg))
                begin
                    pop = 1'b1;
                end
                else
                begin
                    state_next = ST_PUSH;
                end

                if (pop && emit_ok)
                begin
                    hold_next     = '{ch: sym(top_code), cvalid: 1'b1, last: 1'b0,
                                      done: 1'b0, ovf: ovf_reg};
                    hold_vld_next = 1'b1;
                    count_next    = count_reg - CW'(1);
                end
            end
            ST_PUSH:
            begin
                if (count_reg >= CW'(STACK_DEPTH))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_ENDCHK;
            end
            ST_ENDCHK:
            begin
                if (end_reg)
                begin
                    kind_next  = KIND_FLUSH;
                    state_next = ST_EVAL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (hold_vld_reg)
                begin
                    hold_next.last  = 1'b1;
                    hold_next.done  = end_reg;
                    hold_final_next = 1'b1;
                end
                else if (end_reg)
                begin
                    // end marker with nothing emitted
                    hold_next       = '{ch: CH_NUL, cvalid: 1'b0, last: 1'b1,
                                        done: 1'b1, ovf: ovf_reg};
                    hold_vld_next   = 1'b1;
                    hold_final_next = 1'b1;
                end
                if (end_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            hold_vld_reg   <= 1'b0;
            hold_final_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            hold_vld_reg   <= hold_vld_next;
            hold_final_reg <= hold_final_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        code_reg <= code_next;
        char_reg <= char_next;
        end_reg  <= end_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg.ch;
    assign m_tuser  = {out_reg.ovf, out_reg.done, out_reg.cvalid};
    assign m_tlast  = out_reg.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (count_reg < CW'(STACK_DEPTH)))
        else $error("stack write while full");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("expression end not on last result of item");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && end_reg) |=> (count_reg == '0 && !ovf_reg))
        else $error("stack not cleared after expression end");

endmodule

// File: rtl/core/ipc_stack_ram.sv
// Operator stack storage: one write port, one read port, registered read data.
// Depends on ipc_pkg for the entry width.
module ipc_stack_ram #(
    parameter int DEPTH = ipc_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  ipc_pkg::code_t      wdata,
    input  logic [AW-1:0]       raddr,
    output ipc_pkg::code_t      rdata
);
    import ipc_pkg::*;

    code_t mem [DEPTH];
    code_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
